@@ sv/bda_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce package
// Shared constants, types and the d-pad encoder for the debounce block.
// ----------------------------------------------------------------------------
package bda_pkg;

   localparam int NUM_BUTTONS = 8;
   localparam int PIN_W       = 8;
   localparam int TIMER_W     = 16;
   localparam int FRAME_W     = 8;
   localparam int DELAY_W     = 15;
   localparam int DPAD_W      = 4;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int RSP_DATA_W  = 40;

   // Configuration register indexes (byte address / 4).
   typedef enum logic [1:0] {
      REG_FRAME_MS           = 2'd0,
      REG_REPEAT_INITIAL_MS  = 2'd1,
      REG_REPEAT_INTERVAL_MS = 2'd2
   } csr_reg_type;

   localparam logic [FRAME_W-1:0] FRAME_MS_RESET           = 8'd16;
   localparam logic [DELAY_W-1:0] REPEAT_INITIAL_MS_RESET  = 15'd500;
   localparam logic [DELAY_W-1:0] REPEAT_INTERVAL_MS_RESET = 15'd100;

   // D-pad direction codes, clockwise from up.
   localparam logic signed [DPAD_W-1:0] DPAD_UP         = 4'sd0;
   localparam logic signed [DPAD_W-1:0] DPAD_UP_RIGHT   = 4'sd1;
   localparam logic signed [DPAD_W-1:0] DPAD_RIGHT      = 4'sd2;
   localparam logic signed [DPAD_W-1:0] DPAD_DOWN_RIGHT = 4'sd3;
   localparam logic signed [DPAD_W-1:0] DPAD_DOWN       = 4'sd4;
   localparam logic signed [DPAD_W-1:0] DPAD_DOWN_LEFT  = 4'sd5;
   localparam logic signed [DPAD_W-1:0] DPAD_LEFT       = 4'sd6;
   localparam logic signed [DPAD_W-1:0] DPAD_UP_LEFT    = 4'sd7;
   localparam logic signed [DPAD_W-1:0] DPAD_NONE       = -4'sd1;

   typedef struct packed {
      logic [FRAME_W-1:0] frame_ms;
      logic [DELAY_W-1:0] repeat_initial_ms;
      logic [DELAY_W-1:0] repeat_interval_ms;
   } cfg_type;

   typedef struct packed {
      logic signed [DPAD_W-1:0] dpad_direction;
      logic [PIN_W-1:0]         repeat_pulses;
      logic [PIN_W-1:0]         release_edges;
      logic [PIN_W-1:0]         press_edges;
      logic [PIN_W-1:0]         pressed_mask;
   } rsp_type;

   // Buttons 0..3 are up, down, left, right. Up beats down, left beats right.
   function automatic logic signed [DPAD_W-1:0] dpad_code(input logic [3:0] held);
      logic up, down, left, right;
      logic signed [DPAD_W-1:0] code;
      up    = held[0];
      down  = held[1];
      left  = held[2];
      right = held[3];
      if (up && left)        code = DPAD_UP_LEFT;
      else if (up && right)  code = DPAD_UP_RIGHT;
      else if (down && left) code = DPAD_DOWN_LEFT;
      else if (down && right) code = DPAD_DOWN_RIGHT;
      else if (up)           code = DPAD_UP;
      else if (down)         code = DPAD_DOWN;
      else if (left)         code = DPAD_LEFT;
      else if (right)        code = DPAD_RIGHT;
      else                   code = DPAD_NONE;
      return code;
   endfunction

endpackage

@@ sv/bda_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Debounce configuration registers
// APB-style register file holding frame time and auto-repeat delays.
// ----------------------------------------------------------------------------
module bda_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bda_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [bda_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [bda_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready,
   output bda_pkg::cfg_type                    cfg
);

   bda_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr[3:2])
            bda_pkg::REG_FRAME_MS: begin
               cfg_in.frame_ms = csr_pwdata[bda_pkg::FRAME_W-1:0];
            end
            bda_pkg::REG_REPEAT_INITIAL_MS: begin
               cfg_in.repeat_initial_ms = csr_pwdata[bda_pkg::DELAY_W-1:0];
            end
            bda_pkg::REG_REPEAT_INTERVAL_MS: begin
               cfg_in.repeat_interval_ms = csr_pwdata[bda_pkg::DELAY_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         bda_pkg::REG_FRAME_MS: begin
            csr_prdata = {{(bda_pkg::CSR_DATA_W-bda_pkg::FRAME_W){1'b0}}, cfg_ff.frame_ms};
         end
         bda_pkg::REG_REPEAT_INITIAL_MS: begin
            csr_prdata = {{(bda_pkg::CSR_DATA_W-bda_pkg::DELAY_W){1'b0}},
                          cfg_ff.repeat_initial_ms};
         end
         bda_pkg::REG_REPEAT_INTERVAL_MS: begin
            csr_prdata = {{(bda_pkg::CSR_DATA_W-bda_pkg::DELAY_W){1'b0}},
                          cfg_ff.repeat_interval_ms};
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_ms           <= bda_pkg::FRAME_MS_RESET;
         cfg_ff.repeat_initial_ms  <= bda_pkg::REPEAT_INITIAL_MS_RESET;
         cfg_ff.repeat_interval_ms <= bda_pkg::REPEAT_INTERVAL_MS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ sv/bda_repeat.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Auto-repeat timer
// Per-button hold timer that pulses after the initial delay and then once
// per repeat interval while the button stays pressed.
// ----------------------------------------------------------------------------
module bda_repeat (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             held,
   input  logic             press,
   input  bda_pkg::cfg_type cfg,
   output logic             pulse
);

   logic [bda_pkg::TIMER_W-1:0] hold_timer_ff, hold_timer_in;
   logic                        repeating_ff, repeating_in;
   logic [bda_pkg::TIMER_W-1:0] base;
   logic [bda_pkg::TIMER_W-1:0] sum;
   logic [bda_pkg::TIMER_W-1:0] limit;
   logic                        rep_base;
   logic                        reached;

   always_comb begin
      // A fresh press starts from a cleared timer.
      base     = press ? '0 : hold_timer_ff;
      rep_base = press ? 1'b0 : repeating_ff;
      sum      = base + {{(bda_pkg::TIMER_W-bda_pkg::FRAME_W){1'b0}}, cfg.frame_ms};
      limit    = rep_base ? {1'b0, cfg.repeat_interval_ms} : {1'b0, cfg.repeat_initial_ms};
      reached  = (sum >= limit);

      pulse         = 1'b0;
      hold_timer_in = '0;
      repeating_in  = 1'b0;
      if (held) begin
         pulse         = reached;
         hold_timer_in = reached ? '0 : sum;
         repeating_in  = rep_base || reached;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_timer_ff <= '0;
         repeating_ff  <= 1'b0;
      end else if (advance) begin
         hold_timer_ff <= hold_timer_in;
         repeating_ff  <= repeating_in;
      end
   end

endmodule

@@ sv/bda_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Debounce core
// Two-sample debounce, edge detection, auto-repeat timers and d-pad encoding
// for one frame tick.
// ----------------------------------------------------------------------------
module bda_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [bda_pkg::PIN_W-1:0]     pin_levels,
   input  bda_pkg::cfg_type              cfg,
   output bda_pkg::rsp_type              result
);

   localparam int NB = bda_pkg::NUM_BUTTONS;

   logic [NB-1:0] previous_sample_ff;
   logic [NB-1:0] stable_buttons_ff;
   logic [NB-1:0] raw;
   logic [NB-1:0] current;
   logic [NB-1:0] changed;
   logic [NB-1:0] pressed;
   logic [NB-1:0] released;
   logic [NB-1:0] pulses;

   // Pins are active low; buttons past the pin width read as released.
   for (genvar b = 0; b < NB; b++) begin : g_raw
      if (b < bda_pkg::PIN_W) begin : g_pin
         assign raw[b] = ~pin_levels[b];
      end else begin : g_none
         assign raw[b] = 1'b0;
      end
   end

   assign current  = (raw == previous_sample_ff) ? raw : stable_buttons_ff;
   assign changed  = current ^ stable_buttons_ff;
   assign pressed  = current & changed;
   assign released = ~current & changed;

   for (genvar b = 0; b < NB; b++) begin : g_btn
      bda_repeat u_repeat (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .held    (current[b]),
         .press   (pressed[b]),
         .cfg     (cfg),
         .pulse   (pulses[b])
      );
   end

   for (genvar i = 0; i < bda_pkg::PIN_W; i++) begin : g_out
      if (i < NB) begin : g_live
         assign result.pressed_mask[i]  = current[i];
         assign result.press_edges[i]   = pressed[i];
         assign result.release_edges[i] = released[i];
         assign result.repeat_pulses[i] = pulses[i];
      end else begin : g_zero
         assign result.pressed_mask[i]  = 1'b0;
         assign result.press_edges[i]   = 1'b0;
         assign result.release_edges[i] = 1'b0;
         assign result.repeat_pulses[i] = 1'b0;
      end
   end

   assign result.dpad_direction = bda_pkg::dpad_code(current[3:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_sample_ff <= '0;
         stable_buttons_ff  <= '0;
      end else if (advance) begin
         previous_sample_ff <= raw;
         stable_buttons_ff  <= current;
      end
   end

endmodule

@@ sv/button_debounce_autorepeat.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce with auto-repeat
// Debounces eight active-low buttons per frame tick, reports edges, per-button
// auto-repeat pulses and an eight-way d-pad direction.
//
//   Channel | Dir | Handshake         | Payload
//   req     | in  | tvalid / tready   | tdata[7:0] pin_levels
//   rsp     | out | tvalid / tready   | tdata[39:0] masks, pulses, d-pad
//   csr     | in  | psel / penable    | three config registers at 0x0, 0x4, 0x8
//
// One transaction per clock is sustained while the output does not stall: an
// input register feeds the debounce and timer logic. When a transaction leaves
// it, its result lands in the output register and the button state updates,
// so back-to-back ticks see each other's effect. A stalled output holds its
// transaction and the input register fills before req_tready drops.
// Synchronous reset clears all button state and loads the register defaults.
// ----------------------------------------------------------------------------
module button_debounce_autorepeat (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bda_pkg::PIN_W-1:0]          req_tdata,   // [7:0] pin_levels
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] pressed_mask, [15:8] press_edges, [23:16] release_edges,
   // [31:24] repeat_pulses, [35:32] dpad_direction, [39:36] zero
   output logic [bda_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bda_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [bda_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [bda_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   bda_pkg::cfg_type              cfg;
   bda_pkg::rsp_type              result;
   logic                          in_valid_ff, in_valid_in;
   logic [bda_pkg::PIN_W-1:0]     pin_ff;
   logic                          out_valid_ff, out_valid_in;
   bda_pkg::rsp_type              out_data_ff;
   logic                          advance;
   logic                          req_accept;

   bda_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bda_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .pin_levels (pin_ff),
      .cfg        (cfg),
      .result     (result)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         pin_ff <= req_tdata;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(bda_pkg::RSP_DATA_W-$bits(bda_pkg::rsp_type)){1'b0}}, out_data_ff};

   // A transaction leaving the input register always shows up at the output.
   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("output register not loaded after advance");

   a_edges_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((out_data_ff.press_edges & out_data_ff.release_edges) == '0))
      else $error("button pressed and released on the same tick");

   a_edges_match_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (((out_data_ff.press_edges & ~out_data_ff.pressed_mask) == '0) &&
                      ((out_data_ff.release_edges & out_data_ff.pressed_mask) == '0)))
      else $error("edge disagrees with debounced state");

   a_dpad_none: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((out_data_ff.pressed_mask[3:0] == 4'd0) ==
                      (out_data_ff.dpad_direction == bda_pkg::DPAD_NONE)))
      else $error("d-pad direction disagrees with direction buttons");

   a_pulse_needs_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((out_data_ff.repeat_pulses & ~out_data_ff.pressed_mask) == '0))
      else $error("repeat pulse on a released button");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce with auto-repeat testbench
// Sends frame ticks of active-low pin levels and compares every report with
// a cycle-free model of the debounce, edge, auto-repeat and d-pad logic.
// It goes through several timing register settings and idle mixes.
// ----------------------------------------------------------------------------
module tb;

   localparam int PHASE_ITEMS  = 215;
   localparam int NUM_PHASES   = 8;
   localparam int QUIET_LIMIT  = 2000;
   localparam int HOLD_CAP     = 300;

   // Tracks the debounced button state and the repeat timers, and holds the
   // reports that the block still owes.
   class debounce_scoreboard;
      logic [bda_pkg::FRAME_W-1:0] frame_ms;
      logic [bda_pkg::DELAY_W-1:0] initial_ms;
      logic [bda_pkg::DELAY_W-1:0] interval_ms;
      logic [bda_pkg::PIN_W-1:0]   last_raw;
      logic [bda_pkg::PIN_W-1:0]   held;
      logic [bda_pkg::TIMER_W-1:0] hold_ms [bda_pkg::NUM_BUTTONS];
      logic                        auto_on [bda_pkg::NUM_BUTTONS];
      bda_pkg::rsp_type            expected_reports [$];
      int                          failures;
      int                          ticks;
      int                          checked;
      int                          pulse_count;
      int                          press_count;

      function new();
         frame_ms    = bda_pkg::FRAME_MS_RESET;
         initial_ms  = bda_pkg::REPEAT_INITIAL_MS_RESET;
         interval_ms = bda_pkg::REPEAT_INTERVAL_MS_RESET;
         last_raw    = '0;
         held        = '0;
         foreach (hold_ms[b]) begin
            hold_ms[b] = '0;
            auto_on[b] = 1'b0;
         end
         failures    = 0;
         ticks       = 0;
         checked     = 0;
         pulse_count = 0;
         press_count = 0;
      endfunction

      function void write_reg(bda_pkg::csr_reg_type index,
                              logic [bda_pkg::CSR_DATA_W-1:0] value);
         case (index)
            bda_pkg::REG_FRAME_MS:           frame_ms    = value[bda_pkg::FRAME_W-1:0];
            bda_pkg::REG_REPEAT_INITIAL_MS:  initial_ms  = value[bda_pkg::DELAY_W-1:0];
            bda_pkg::REG_REPEAT_INTERVAL_MS: interval_ms = value[bda_pkg::DELAY_W-1:0];
            default: ;
         endcase
      endfunction

      // Vertical axis: 1 up, 2 down. Horizontal axis: 1 left, 2 right.
      function logic signed [bda_pkg::DPAD_W-1:0] direction(logic [3:0] keys);
         logic [1:0]                        vert;
         logic [1:0]                        horiz;
         logic signed [bda_pkg::DPAD_W-1:0] code;
         vert  = keys[0] ? 2'd1 : (keys[1] ? 2'd2 : 2'd0);
         horiz = keys[2] ? 2'd1 : (keys[3] ? 2'd2 : 2'd0);
         case ({vert, horiz})
            4'b0100: code = bda_pkg::DPAD_UP;
            4'b0101: code = bda_pkg::DPAD_UP_LEFT;
            4'b0110: code = bda_pkg::DPAD_UP_RIGHT;
            4'b1000: code = bda_pkg::DPAD_DOWN;
            4'b1001: code = bda_pkg::DPAD_DOWN_LEFT;
            4'b1010: code = bda_pkg::DPAD_DOWN_RIGHT;
            4'b0001: code = bda_pkg::DPAD_LEFT;
            4'b0010: code = bda_pkg::DPAD_RIGHT;
            default: code = bda_pkg::DPAD_NONE;
         endcase
         return code;
      endfunction

      function void note_tick(logic [bda_pkg::PIN_W-1:0] pins);
         logic [bda_pkg::PIN_W-1:0] raw;
         logic [bda_pkg::PIN_W-1:0] now_held;
         logic [bda_pkg::PIN_W-1:0] changed;
         bda_pkg::rsp_type          r;
         int                        b;
         raw = ~pins;
         if (raw == last_raw) begin
            now_held = raw;
         end else begin
            last_raw = raw;
            now_held = held;
         end
         changed         = now_held ^ held;
         r.pressed_mask  = now_held;
         r.press_edges   = now_held & changed;
         r.release_edges = ~now_held & changed;
         r.repeat_pulses = '0;
         for (b = 0; b < bda_pkg::NUM_BUTTONS; b++) begin
            if (!now_held[b] || r.press_edges[b]) begin
               hold_ms[b] = '0;
               auto_on[b] = 1'b0;
            end
            if (now_held[b]) begin
               hold_ms[b] = hold_ms[b] + frame_ms;
               if (!auto_on[b] && hold_ms[b] >= initial_ms) begin
                  auto_on[b]         = 1'b1;
                  hold_ms[b]         = '0;
                  r.repeat_pulses[b] = 1'b1;
               end else if (auto_on[b] && hold_ms[b] >= interval_ms) begin
                  hold_ms[b]         = '0;
                  r.repeat_pulses[b] = 1'b1;
               end
            end
         end
         r.dpad_direction = direction(now_held[3:0]);
         held = now_held;
         expected_reports.push_back(r);
         ticks++;
         pulse_count += $countones(r.repeat_pulses);
         press_count += $countones(r.press_edges);
      endfunction

      function void flag(string what);
         failures++;
         if (failures <= 10) $display("MISMATCH %s", what);
      endfunction

      function void check_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want)
            flag($sformatf("report %0d %s: expected %h, got %h", checked, name, want, got));
      endfunction

      function void check_report(logic [bda_pkg::RSP_DATA_W-1:0] data);
         bda_pkg::rsp_type want;
         bda_pkg::rsp_type got;
         if (expected_reports.size() == 0) begin
            flag($sformatf("report %h arrived with no tick waiting", data));
            return;
         end
         want = expected_reports.pop_front();
         got  = bda_pkg::rsp_type'(data[$bits(bda_pkg::rsp_type)-1:0]);
         check_field("pressed_mask", want.pressed_mask, got.pressed_mask);
         check_field("press_edges", want.press_edges, got.press_edges);
         check_field("release_edges", want.release_edges, got.release_edges);
         check_field("repeat_pulses", want.repeat_pulses, got.repeat_pulses);
         check_field("dpad_direction", {4'h0, want.dpad_direction},
                     {4'h0, got.dpad_direction});
         check_field("padding", 8'h00,
                     {4'h0, data[bda_pkg::RSP_DATA_W-1:$bits(bda_pkg::rsp_type)]});
         checked++;
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [bda_pkg::PIN_W-1:0]      req_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [bda_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [bda_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [bda_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [bda_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   debounce_scoreboard predictor = new();
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int quiet_cycles       = 0;
   int settings_used      = 1;

   // Pressed masks for the directed part: all released, all pressed, a
   // one-tick release glitch that must be ignored, then every d-pad case but
   // up-left, including opposite buttons held together.
   logic [bda_pkg::PIN_W-1:0] directed_masks [24] = '{
      8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF,
      8'h09, 8'h09, 8'h06, 8'h06, 8'h0A, 8'h0A,
      8'h03, 8'h03, 8'h0C, 8'h0C, 8'h01, 8'h01,
      8'h02, 8'h02, 8'h04, 8'h04, 8'h08, 8'h08
   };

   button_debounce_autorepeat i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Both channels are sampled here, with the values that the block sees at
   // this edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) predictor.note_tick(req_tdata);
         if (rsp_tvalid && rsp_tready) predictor.check_report(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
               $display("CHECKS FAILED");
               $finish;
            end
         end
      end
   end

   task automatic send_tick(input logic [bda_pkg::PIN_W-1:0] pins);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= bda_pkg::PIN_W'($urandom);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pins;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Returns aligned to a rising edge once every owed report has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (predictor.expected_reports.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_csr(input bda_pkg::csr_reg_type index,
                            input logic [bda_pkg::CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      predictor.write_reg(index, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Held patterns that change one button, the d-pad buttons or the whole mask,
   // some held long enough for several repeat pulses, plus one-tick noise.
   task automatic run_phase(input int budget);
      int                        left;
      int                        hold;
      int                        target;
      logic [bda_pkg::PIN_W-1:0] mask;
      left   = budget;
      mask   = '0;
      target = predictor.initial_ms / predictor.frame_ms
               + 3 * (predictor.interval_ms / predictor.frame_ms + 1) + 2;
      if (target > HOLD_CAP) target = HOLD_CAP;
      while (left > 0) begin
         case ($urandom_range(9))
            0:       mask = '0;
            1:       mask = '1;
            2, 3:    mask = bda_pkg::PIN_W'($urandom);
            4, 5, 6: mask = mask ^ (bda_pkg::PIN_W'(1) << $urandom_range(bda_pkg::PIN_W - 1));
            7:       mask = {mask[bda_pkg::PIN_W-1:4], 4'($urandom)};
            default: mask = bda_pkg::PIN_W'(1) << $urandom_range(bda_pkg::PIN_W - 1);
         endcase
         if ($urandom_range(9) == 0) begin
            hold = 1;
            send_tick(bda_pkg::PIN_W'($urandom));
         end else begin
            hold = ($urandom_range(3) == 0) ? $urandom_range(target, target / 2)
                                            : $urandom_range(6, 1);
            if (hold > left) hold = left;
            repeat (hold) send_tick(~mask);
         end
         left -= hold;
      end
   endtask

   initial begin
      int                          p;
      logic [bda_pkg::FRAME_W-1:0] frame;
      logic [bda_pkg::DELAY_W-1:0] first_delay;
      logic [bda_pkg::DELAY_W-1:0] next_delay;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      rsp_tready  <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_masks[i]) send_tick(~directed_masks[i]);
      run_phase(PHASE_ITEMS);

      for (p = 1; p < NUM_PHASES; p++) begin
         case (p)
            1: begin frame = 8'd1;   first_delay = 15'd0;     next_delay = 15'd0;     end
            2: begin frame = 8'd255; first_delay = 15'd32767; next_delay = 15'd32767; end
            3: begin frame = 8'd255; first_delay = 15'd0;     next_delay = 15'd32767; end
            4: begin frame = 8'd16;  first_delay = 15'd200;   next_delay = 15'd0;     end
            5: begin frame = 8'd3;   first_delay = 15'd10;    next_delay = 15'd4;     end
            default: begin
               frame       = bda_pkg::FRAME_W'($urandom_range(255, 1));
               first_delay = bda_pkg::DELAY_W'($urandom_range(600));
               next_delay  = bda_pkg::DELAY_W'($urandom_range(300));
            end
         endcase
         drain();
         write_csr(bda_pkg::REG_FRAME_MS, bda_pkg::CSR_DATA_W'(frame));
         write_csr(bda_pkg::REG_REPEAT_INITIAL_MS, bda_pkg::CSR_DATA_W'(first_delay));
         write_csr(bda_pkg::REG_REPEAT_INTERVAL_MS, bda_pkg::CSR_DATA_W'(next_delay));
         settings_used++;
         case (p % 4)
            1:       begin sender_idle_pct = 79; receiver_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  receiver_stall_pct = 79; end
            3:       begin sender_idle_pct = 10; receiver_stall_pct = 10; end
            default: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         endcase
         run_phase(PHASE_ITEMS);
      end

      drain();
      repeat (4) @(posedge clock);
      $display("Sent %0d ticks under %0d timing settings and four idle mixes.",
               predictor.ticks, settings_used);
      $display("Checked %0d reports with %0d press edges and %0d repeat pulses.",
               predictor.checked, predictor.press_count, predictor.pulse_count);
      if (predictor.failures == 0 && predictor.expected_reports.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/bda_pkg.sv
sv/bda_csr.sv
sv/bda_repeat.sv
sv/bda_core.sv
sv/button_debounce_autorepeat.sv
dv/tb.sv
